@@ design/assert_macros.svh @@
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/tlik_pkg.sv @@
`timescale 1ns / 1ps
package tlik_pkg;

	localparam int X_W    = 14;
	localparam int Z_W    = 13;
	localparam int LEN_W  = 13;
	localparam int OFF_W  = 8;
	localparam int CMD_W  = 8;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 13;
	// CORDIC datapath width and law-of-cosines operand width
	localparam int DATA_W = 34;
	localparam int NUM_W  = 37;

	localparam logic [30:0] PIH_Q30         = 31'd1686629713;
	localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;
	localparam logic [CMD_W-1:0] CMD_MAX    = 8'd180;

	typedef enum logic [IDX_W-1:0] {
		REG_UPPER_LEN  = 3'd0,
		REG_LOWER_LEN  = 3'd1,
		REG_LEFT_HIP   = 3'd2,
		REG_LEFT_KNEE  = 3'd3,
		REG_LEFT_ANKLE = 3'd4,
		REG_RIGHT_HIP  = 3'd5,
		REG_RIGHT_KNEE = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic valid;
		logic ok;
	} acos_status_t;

	// atan(2^-i) in radians, 30 fraction bits
	function automatic logic [29:0] atan_q30(input int unsigned idx);
		case (idx)
			0:  atan_q30 = 30'd843314857;
			1:  atan_q30 = 30'd497837829;
			2:  atan_q30 = 30'd263043836;
			3:  atan_q30 = 30'd133525158;
			4:  atan_q30 = 30'd67021686;
			5:  atan_q30 = 30'd33543515;
			6:  atan_q30 = 30'd16775850;
			7:  atan_q30 = 30'd8388437;
			8:  atan_q30 = 30'd4194282;
			9:  atan_q30 = 30'd2097149;
			10: atan_q30 = 30'd1048575;
			11: atan_q30 = 30'd524287;
			12: atan_q30 = 30'd262143;
			13: atan_q30 = 30'd131071;
			14: atan_q30 = 30'd65535;
			15: atan_q30 = 30'd32767;
			16: atan_q30 = 30'd16383;
			17: atan_q30 = 30'd8191;
			18: atan_q30 = 30'd4095;
			19: atan_q30 = 30'd2047;
			20: atan_q30 = 30'd1023;
			21: atan_q30 = 30'd511;
			22: atan_q30 = 30'd255;
			23: atan_q30 = 30'd127;
			default: atan_q30 = 30'd0;
		endcase
	endfunction

endpackage

@@ design/tlik_isqrt.sv @@
`timescale 1ns / 1ps
// Pipelined floor square root, one result bit per stage.
module tlik_isqrt #(
	parameter int W   = 36,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [W-1:0]   in_value,
	input  logic [SBW-1:0] in_sb,
	output logic           out_valid,
	output logic [W/2-1:0] out_root,
	output logic [SBW-1:0] out_sb
);
	localparam int RW = W / 2;

	logic [W-1:0]    val_s  [0:RW-1];
	logic [RW+1:0]   rem_s  [0:RW];
	logic [RW-1:0]   root_s [0:RW];
	logic [SBW-1:0]  sb_s   [0:RW];
	logic [RW:0]     v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[RW-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s[0]  <= in_value;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			sb_s[0]   <= in_sb;
		end
	end

	for (genvar k = 0; k < RW; k++) begin : g_digit
		logic [RW+1:0] rem_t, trial, diff;
		assign rem_t = {rem_s[k][RW-1:0], val_s[k][W-1 -: 2]};
		assign trial = {root_s[k], 2'b01};
		assign diff  = rem_t - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k+1] <= sb_s[k];
				if (rem_t >= trial) begin
					rem_s[k+1]  <= diff;
					root_s[k+1] <= {root_s[k][RW-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= rem_t;
					root_s[k+1] <= {root_s[k][RW-2:0], 1'b0};
				end
			end
		end

		if (k < RW - 1) begin : g_shift
			always_ff @(posedge clk) begin
				if (en) begin
					val_s[k+1] <= {val_s[k][W-3:0], 2'b00};
				end
			end
		end
	end

	assign out_valid = v_s[RW];
	assign out_root  = root_s[RW];
	assign out_sb    = sb_s[RW];

endmodule

@@ design/tlik_cordic.sv @@
`timescale 1ns / 1ps
// Pipelined CORDIC vectoring: angle of (x, y), one micro-rotation per stage.
module tlik_cordic import tlik_pkg::*; #(
	parameter int N   = 16,
	parameter int AFB = 16,
	parameter int SBW = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [DATA_W-1:0] in_x,
	input  logic signed [DATA_W-1:0] in_y,
	input  logic [SBW-1:0]           in_sb,
	output logic                     out_valid,
	output logic signed [AFB+3:0]    out_angle,
	output logic [SBW-1:0]           out_sb
);
	localparam int AW = AFB + 4;
	localparam logic signed [AW-1:0] HALF_PI = AW'(PIH_Q30 >> (30 - AFB));

	logic signed [DATA_W-1:0] x_s [0:N-1];
	logic signed [DATA_W-1:0] y_s [0:N-1];
	logic signed [AW-1:0]     a_s [0:N];
	logic [SBW-1:0]           sb_s [0:N];
	logic [N:0]               v_s;

	logic signed [DATA_W-1:0] x0, y0;
	logic signed [AW-1:0]     a0;

	// fold the left half-plane onto the right one
	always_comb begin
		x0 = in_x;
		y0 = in_y;
		a0 = '0;
		if (in_x < 0) begin
			if (in_y >= 0) begin
				x0 = in_y;
				y0 = -in_x;
				a0 = HALF_PI;
			end else begin
				x0 = -in_y;
				y0 = in_x;
				a0 = -HALF_PI;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[N-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= x0;
			y_s[0]  <= y0;
			a_s[0]  <= a0;
			sb_s[0] <= in_sb;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		localparam logic signed [AW-1:0] STEP = AW'(atan_q30(i) >> (30 - AFB));

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[i+1] <= sb_s[i];
				if (y_s[i] > 0) begin
					a_s[i+1] <= a_s[i] + STEP;
				end else begin
					a_s[i+1] <= a_s[i] - STEP;
				end
			end
		end

		if (i < N - 1) begin : g_rot
			always_ff @(posedge clk) begin
				if (en) begin
					if (y_s[i] > 0) begin
						x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					end else begin
						x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					end
				end
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_angle = a_s[N];
	assign out_sb    = sb_s[N];

endmodule

@@ design/tlik_acos.sv @@
`timescale 1ns / 1ps
// Pipelined arccos of num/den: normalize, root of den^2 - num^2, then CORDIC.
module tlik_acos import tlik_pkg::*; #(
	parameter int N   = 16,
	parameter int AFB = 16,
	parameter int SBW = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [NUM_W-1:0] num,
	input  logic [NUM_W-1:0]        den,
	input  logic [SBW-1:0]          in_sb,
	output acos_status_t            out_status,
	output logic signed [AFB+3:0]   out_angle,
	output logic [SBW-1:0]          out_sb
);
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [NUM_W-1:0] m_s1, d_s1;
	logic [29:0]      m_s2, d_s2, m_s3, d_s3, m_s4, d_s4, m_s5;
	logic [59:0]      dd_s5, mm_s5;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic ok_s1, ok_s2, ok_s3, ok_s4, ok_s5;
	logic [SBW-1:0] sb_s1, sb_s2, sb_s3, sb_s4, sb_s5;

	logic [NUM_W-1:0] m_abs, d_r, m_r;
	logic [29:0]      d_l1, m_l1, d_l2, m_l2;

	assign m_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

	// bring den below 2^30, truncating both
	always_comb begin
		d_r = d_s1;
		m_r = m_s1;
		if (|d_r[NUM_W-1:33]) begin
			d_r = d_r >> 4;
			m_r = m_r >> 4;
		end
		if (|d_r[NUM_W-1:31]) begin
			d_r = d_r >> 2;
			m_r = m_r >> 2;
		end
		if (|d_r[NUM_W-1:30]) begin
			d_r = d_r >> 1;
			m_r = m_r >> 1;
		end
	end

	// raise den to at least 2^29, coarse steps then fine steps
	always_comb begin
		d_l1 = d_s2;
		m_l1 = m_s2;
		if (~|d_l1[29:14]) begin
			d_l1 = d_l1 << 16;
			m_l1 = m_l1 << 16;
		end
		if (~|d_l1[29:22]) begin
			d_l1 = d_l1 << 8;
			m_l1 = m_l1 << 8;
		end
	end

	always_comb begin
		d_l2 = d_s3;
		m_l2 = m_s3;
		if (~|d_l2[29:26]) begin
			d_l2 = d_l2 << 4;
			m_l2 = m_l2 << 4;
		end
		if (~|d_l2[29:28]) begin
			d_l2 = d_l2 << 2;
			m_l2 = m_l2 << 2;
		end
		if (~d_l2[29]) begin
			d_l2 = d_l2 << 1;
			m_l2 = m_l2 << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1   <= m_abs;
			d_s1   <= den;
			neg_s1 <= num[NUM_W-1];
			ok_s1  <= (den != '0) && (m_abs <= den);
			sb_s1  <= in_sb;

			m_s2   <= m_r[29:0];
			d_s2   <= d_r[29:0];
			neg_s2 <= neg_s1;
			ok_s2  <= ok_s1;
			sb_s2  <= sb_s1;

			m_s3   <= m_l1;
			d_s3   <= d_l1;
			neg_s3 <= neg_s2;
			ok_s3  <= ok_s2;
			sb_s3  <= sb_s2;

			m_s4   <= m_l2;
			d_s4   <= d_l2;
			neg_s4 <= neg_s3;
			ok_s4  <= ok_s3;
			sb_s4  <= sb_s3;

			dd_s5  <= 60'(d_s4) * 60'(d_s4);
			mm_s5  <= 60'(m_s4) * 60'(m_s4);
			m_s5   <= m_s4;
			neg_s5 <= neg_s4;
			ok_s5  <= ok_s4;
			sb_s5  <= sb_s4;
		end
	end

	logic              sq_valid;
	logic [29:0]       sq_root;
	logic [SBW+31:0]   sq_sb;
	logic [29:0]       sq_m;
	logic              sq_neg, sq_ok;
	logic [SBW-1:0]    sq_user;
	logic signed [DATA_W-1:0] cx, cy;
	logic [SBW:0]      c_sb;

	tlik_isqrt #(
		.W   (60),
		.SBW (SBW + 32)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.in_value  (dd_s5 - mm_s5),
		.in_sb     ({ok_s5, neg_s5, m_s5, sb_s5}),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_sb    (sq_sb)
	);

	assign {sq_ok, sq_neg, sq_m, sq_user} = sq_sb;
	assign cx = sq_neg ? -$signed({4'b0, sq_m}) : $signed({4'b0, sq_m});
	assign cy = $signed({4'b0, sq_root});

	tlik_cordic #(
		.N   (N),
		.AFB (AFB),
		.SBW (SBW + 1)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_x      (cx),
		.in_y      (cy),
		.in_sb     ({sq_ok, sq_user}),
		.out_valid (out_status.valid),
		.out_angle (out_angle),
		.out_sb    (c_sb)
	);

	assign out_status.ok = c_sb[SBW];
	assign out_sb        = c_sb[SBW-1:0];

endmodule

@@ design/two_link_leg_inverse_kinematics.sv @@
`timescale 1ns / 1ps
// Two-link leg inverse kinematics. Each input word carries a foot target
// (foot_x signed, foot_z unsigned, both with 8 fraction bits) and a leg select
// in tuser; each output word carries hip, knee and ankle servo commands in
// degrees, saturated to 0..180, with the leg echoed in tuser bit 0 and an
// unreachable flag in tuser bit 1 (all commands zero when it is set). The
// block is a free-running pipeline: it takes one word per clock unless
// output back-pressure freezes it, and returns results in order. On its
// way from input to output, each result crosses
// 2*CORDIC_ITERATIONS + 65 registers: input capture and squared reach (2),
// the lean CORDIC (CORDIC_ITERATIONS + 1), the 19-stage reach square root,
// two law-of-cosines stages, the arccos units (5-stage normalizer, 31-stage
// square root, CORDIC of CORDIC_ITERATIONS + 1 stages), three degree
// conversion stages and the output register. Back-pressure on the output
// freezes the whole pipeline only when a finished result is queued behind a
// full output register. Write the link lengths and servo offsets on the cfg
// channel only while no word is in flight; cfg_ready is always high and
// indexes beyond the last register are dropped.
`include "assert_macros.svh"
module two_link_leg_inverse_kinematics import tlik_pkg::*; #(
	parameter int ANGLE_FRACTION_BITS = 16,
	parameter int CORDIC_ITERATIONS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // foot_x[13:0], foot_z[26:14], zero pad
	input  logic [0:0]       s_tuser,   // leg_select
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,   // hip[7:0], knee[15:8], ankle[23:16]
	output logic [1:0]       m_tuser,   // leg_out, unreachable
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	localparam int AFB = ANGLE_FRACTION_BITS;
	localparam int AW  = AFB + 4;
	localparam int MAG_W = AFB + 3;
	localparam int MW  = MAG_W + 31;
	localparam logic signed [AW-1:0] HALF_PI = AW'(PIH_Q30 >> (30 - AFB));
	// pi is twice the truncated half pi
	localparam logic signed [AW-1:0] PI      = HALF_PI + HALF_PI;

	// ---------------- configuration registers ----------------
	logic [LEN_W-1:0] upper_len_q, lower_len_q;
	logic [OFF_W-1:0] lhip_q, lknee_q, lankle_q, rhip_q, rknee_q;
	logic [33:0]      l1s_q, l2s_q;
	logic [34:0]      l12_q;
	logic [16:0]      l1, l2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_len_q <= 13'd1280;
			lower_len_q <= 13'd1280;
			lhip_q      <= 8'd90;
			lknee_q     <= 8'd90;
			lankle_q    <= 8'd90;
			rhip_q      <= 8'd90;
			rknee_q     <= 8'd90;
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_UPPER_LEN:  upper_len_q <= cfg_data;
				REG_LOWER_LEN:  lower_len_q <= cfg_data;
				REG_LEFT_HIP:   lhip_q      <= cfg_data[OFF_W-1:0];
				REG_LEFT_KNEE:  lknee_q     <= cfg_data[OFF_W-1:0];
				REG_LEFT_ANKLE: lankle_q    <= cfg_data[OFF_W-1:0];
				REG_RIGHT_HIP:  rhip_q      <= cfg_data[OFF_W-1:0];
				REG_RIGHT_KNEE: rknee_q     <= cfg_data[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// link lengths with 12 fraction bits; their products only change with cfg
	assign l1 = {upper_len_q, 4'b0};
	assign l2 = {lower_len_q, 4'b0};

	always_ff @(posedge clk) begin
		l1s_q <= 34'(l1) * 34'(l1);
		l2s_q <= 34'(l2) * 34'(l2);
		l12_q <= {34'(l1) * 34'(l2), 1'b0};
	end

	// ---------------- pipeline advance ----------------
	// Freeze only when the last stage holds a word the output cannot take.
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, out_v_q;

	assign en       = !(v_s7 && out_v_q && !m_tready);
	assign s_tready = en;

	// ---------------- s1: capture, s2: squared reach ----------------
	logic signed [X_W-1:0] x_s1, x_s2;
	logic [Z_W-1:0]        z_s1, z_s2;
	logic                  leg_s1, leg_s2;
	logic [26:0]           r2_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= s_tdata[X_W-1:0];
			z_s1   <= s_tdata[X_W +: Z_W];
			leg_s1 <= s_tuser[0];
			x_s2   <= x_s1;
			z_s2   <= z_s1;
			leg_s2 <= leg_s1;
			r2_s2  <= 27'(28'($signed(x_s1) * $signed(x_s1)) + 28'(z_s1 * z_s1));
		end
	end

	// ---------------- lean = atan2(x, z) ----------------
	logic                 lean_v;
	logic signed [AW-1:0] lean;
	logic [27:0]          lean_sb;

	tlik_cordic #(
		.N   (CORDIC_ITERATIONS),
		.AFB (AFB),
		.SBW (28)
	) u_lean (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_x      ($signed({5'b0, z_s2, 16'b0})),
		.in_y      ($signed({{4{x_s2[X_W-1]}}, x_s2, 16'b0})),
		.in_sb     ({leg_s2, r2_s2}),
		.out_valid (lean_v),
		.out_angle (lean),
		.out_sb    (lean_sb)
	);

	// ---------------- reach R = sqrt(r2) with 12 fraction bits ----------------
	logic              reach_v;
	logic [17:0]       reach;
	logic [AW+27:0]    reach_sb;
	logic signed [AW-1:0] lean_r;
	logic              leg_r;
	logic [26:0]       r2_r;

	tlik_isqrt #(
		.W   (36),
		.SBW (AW + 28)
	) u_reach (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (lean_v),
		.in_value  ({1'b0, lean_sb[26:0], 8'b0}),
		.in_sb     ({lean, lean_sb}),
		.out_valid (reach_v),
		.out_root  (reach),
		.out_sb    (reach_sb)
	);

	assign {lean_r, leg_r, r2_r} = reach_sb;

	// ---------------- s3: products, s4: law-of-cosines terms ----------------
	logic [35:0]          rl1_s3, rl2_s3;
	logic [34:0]          rs_s3;
	logic signed [AW-1:0] lean_s3, lean_s4;
	logic                 leg_s3, leg_s4;
	logic signed [NUM_W-1:0] num1_s4, num2_s4, num3_s4;
	logic [NUM_W-1:0]     den1_s4, den2_s4, den3_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			rl1_s3  <= {35'(l1) * 35'(reach), 1'b0};
			rl2_s3  <= {35'(l2) * 35'(reach), 1'b0};
			rs_s3   <= {r2_r, 8'b0};
			lean_s3 <= lean_r;
			leg_s3  <= leg_r;

			num1_s4 <= $signed({3'b0, l1s_q}) + $signed({2'b0, rs_s3})
				- $signed({3'b0, l2s_q});
			num2_s4 <= $signed({3'b0, l1s_q}) + $signed({3'b0, l2s_q})
				- $signed({2'b0, rs_s3});
			num3_s4 <= $signed({3'b0, l2s_q}) + $signed({2'b0, rs_s3})
				- $signed({3'b0, l1s_q});
			den1_s4 <= {1'b0, rl1_s3};
			den2_s4 <= {2'b0, l12_q};
			den3_s4 <= {1'b0, rl2_s3};
			lean_s4 <= lean_s3;
			leg_s4  <= leg_s3;
		end
	end

	// ---------------- three arccos units in lockstep ----------------
	acos_status_t         st1, st2, st3;
	logic signed [AW-1:0] a1, a2, a3, lean_a;
	logic                 leg_a2, leg_a3;

	tlik_acos #(.N(CORDIC_ITERATIONS), .AFB(AFB), .SBW(AW)) u_acos_hip (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (v_s4),
		.num        (num1_s4),
		.den        (den1_s4),
		.in_sb      (lean_s4),
		.out_status (st1),
		.out_angle  (a1),
		.out_sb     (lean_a)
	);

	tlik_acos #(.N(CORDIC_ITERATIONS), .AFB(AFB), .SBW(1)) u_acos_knee (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (v_s4),
		.num        (num2_s4),
		.den        (den2_s4),
		.in_sb      (leg_s4),
		.out_status (st2),
		.out_angle  (a2),
		.out_sb     (leg_a2)
	);

	tlik_acos #(.N(CORDIC_ITERATIONS), .AFB(AFB), .SBW(1)) u_acos_ankle (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (v_s4),
		.num        (num3_s4),
		.den        (den3_s4),
		.in_sb      (leg_s4),
		.out_status (st3),
		.out_angle  (a3),
		.out_sb     (leg_a3)
	);

	// ---------------- s5: joint angles, s6: magnitude, s7: to degrees -------
	logic signed [AW-1:0] hip_s5, knee_s5, ankle_s5;
	logic                 ok_s5, ok_s6, ok_s7, leg_s5, leg_s6, leg_s7;
	logic [MAG_W-1:0]     hip_m_s6, knee_m_s6, ankle_m_s6;
	logic                 hip_n_s6, knee_n_s6, ankle_n_s6;
	logic                 hip_n_s7, knee_n_s7, ankle_n_s7;
	logic [MW-1:0]        hip_p_s7, knee_p_s7, ankle_p_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			hip_s5   <= a1 + lean_a;
			knee_s5  <= PI - a2;
			ankle_s5 <= HALF_PI + lean_a - a3;
			ok_s5    <= st1.ok & st2.ok & st3.ok;
			leg_s5   <= leg_a2;

			hip_n_s6   <= hip_s5[AW-1];
			knee_n_s6  <= knee_s5[AW-1];
			ankle_n_s6 <= ankle_s5[AW-1];
			hip_m_s6   <= MAG_W'(hip_s5[AW-1] ? -hip_s5 : hip_s5);
			knee_m_s6  <= MAG_W'(knee_s5[AW-1] ? -knee_s5 : knee_s5);
			ankle_m_s6 <= MAG_W'(ankle_s5[AW-1] ? -ankle_s5 : ankle_s5);
			ok_s6      <= ok_s5;
			leg_s6     <= leg_s5;

			hip_p_s7   <= MW'(hip_m_s6) * MW'(DEG_PER_RAD_Q24);
			knee_p_s7  <= MW'(knee_m_s6) * MW'(DEG_PER_RAD_Q24);
			ankle_p_s7 <= MW'(ankle_m_s6) * MW'(DEG_PER_RAD_Q24);
			hip_n_s7   <= hip_n_s6;
			knee_n_s7  <= knee_n_s6;
			ankle_n_s7 <= ankle_n_s6;
			ok_s7      <= ok_s6;
			leg_s7     <= leg_s6;
		end
	end

	// valid bits of the stages owned here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= reach_v;
			v_s4 <= v_s3;
			v_s5 <= st1.valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// ---------------- offsets and saturation ----------------
	function automatic logic [CMD_W-1:0] sat_cmd(input logic signed [11:0] v);
		logic [CMD_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({4'b0, CMD_MAX})) begin
			r = CMD_MAX;
		end else begin
			r = v[CMD_W-1:0];
		end
		return r;
	endfunction

	logic [9:0]        hip_deg, knee_deg, ankle_deg;
	logic signed [11:0] hip_sv, knee_sv, ankle_sv;
	logic [CMD_W-1:0]  hip_cmd, knee_cmd, ankle_cmd;

	// degrees truncated toward zero: shift the magnitude, then restore the sign
	assign hip_deg   = hip_p_s7[AFB+24 +: 10];
	assign knee_deg  = knee_p_s7[AFB+24 +: 10];
	assign ankle_deg = ankle_p_s7[AFB+24 +: 10];
	assign hip_sv    = hip_n_s7 ? -$signed({2'b0, hip_deg}) : $signed({2'b0, hip_deg});
	assign knee_sv   = knee_n_s7 ? -$signed({2'b0, knee_deg}) : $signed({2'b0, knee_deg});
	assign ankle_sv  = ankle_n_s7 ? -$signed({2'b0, ankle_deg})
		: $signed({2'b0, ankle_deg});

	always_comb begin
		if (!leg_s7) begin
			// left leg mirrors the joints; its ankle neutral counts twice
			hip_cmd   = sat_cmd($signed({4'b0, lhip_q}) - hip_sv);
			knee_cmd  = sat_cmd($signed({4'b0, lknee_q}) - knee_sv);
			ankle_cmd = sat_cmd($signed({3'b0, lankle_q, 1'b0}) - ankle_sv);
		end else begin
			// right ankle carries no neutral offset
			hip_cmd   = sat_cmd($signed({4'b0, rhip_q}) + hip_sv);
			knee_cmd  = sat_cmd($signed({4'b0, rknee_q}) + knee_sv);
			ankle_cmd = sat_cmd(ankle_sv);
		end
		if (!ok_s7) begin
			hip_cmd   = '0;
			knee_cmd  = '0;
			ankle_cmd = '0;
		end
	end

	// ---------------- output register ----------------
	logic [CMD_W-1:0] hip_q, knee_q, ankle_q;
	logic             leg_q, unr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s7 | (out_v_q & !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s7) begin
			hip_q   <= hip_cmd;
			knee_q  <= knee_cmd;
			ankle_q <= ankle_cmd;
			leg_q   <= leg_s7;
			unr_q   <= !ok_s7;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {ankle_q, knee_q, hip_q};
	assign m_tuser  = {unr_q, leg_q};

	// ---------------- checks ----------------
	`ASSERT_IMPLIES(a_acos_lockstep, clk, arst_n, 1'b1,
		st1.valid == st2.valid && st1.valid == st3.valid, "arccos units out of step")
	`ASSERT_IMPLIES(a_acos_align, clk, arst_n, st2.valid, leg_a2 == leg_a3,
		"arccos units carry different words")
	`ASSERT_IMPLIES(a_unreach_zero, clk, arst_n, m_tvalid && m_tuser[1], m_tdata == '0,
		"unreachable result with nonzero commands")
	`ASSERT_IMPLIES(a_cmd_range, clk, arst_n, m_tvalid,
		m_tdata[7:0] <= CMD_MAX && m_tdata[15:8] <= CMD_MAX && m_tdata[23:16] <= CMD_MAX,
		"command above saturation limit")
	`ASSERT_NEXT(a_hold_last, clk, arst_n, v_s7 && out_v_q && !m_tready, v_s7,
		"finished word dropped while output stalled")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import tlik_pkg::*;

	// Index beyond the last register: the block must drop writes to it
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int ANGLE_FB   = 16;
	localparam int CORDIC_IT  = 16;
	localparam int LATENCY    = 2 * CORDIC_IT + 65;
	localparam int STALL_LIMIT = 5000;
	localparam int IDLE_PCT    = 26;

	typedef struct {
		bit             leg;
		bit [CMD_W-1:0] hip;
		bit [CMD_W-1:0] knee;
		bit [CMD_W-1:0] ankle;
		bit             unreach;
	} servo_cmd_t;

	// Keeps a copy of the registers and the servo commands still owed by the block
	class leg_scoreboard;
		longint     upper_len, lower_len;
		longint     off_l_hip, off_l_knee, off_l_ankle, off_r_hip, off_r_knee;
		servo_cmd_t owed_q[$];
		int         errors;
		int         checked;
		int         unreach_seen;

		function new();
			upper_len = 1280;
			lower_len = 1280;
			off_l_hip = 90;
			off_l_knee = 90;
			off_l_ankle = 90;
			off_r_hip = 90;
			off_r_knee = 90;
			errors = 0;
			checked = 0;
			unreach_seen = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_UPPER_LEN:  upper_len = val;
				REG_LOWER_LEN:  lower_len = val;
				REG_LEFT_HIP:   off_l_hip = val[OFF_W-1:0];
				REG_LEFT_KNEE:  off_l_knee = val[OFF_W-1:0];
				REG_LEFT_ANKLE: off_l_ankle = val[OFF_W-1:0];
				REG_RIGHT_HIP:  off_r_hip = val[OFF_W-1:0];
				REG_RIGHT_KNEE: off_r_knee = val[OFF_W-1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function longint half_pi();
			return longint'(PIH_Q30) >>> (30 - ANGLE_FB);
		endfunction

		// CORDIC vectoring: angle of (x, y)
		function longint vector_angle(longint x, longint y);
			longint base, acc, t, stp, dx, dy;
			base = 0;
			acc = 0;
			if (x < 0) begin
				if (y >= 0) begin
					t = x; x = y; y = -t; base = half_pi();
				end else begin
					t = x; x = -y; y = t; base = -half_pi();
				end
			end
			for (int i = 0; i < CORDIC_IT; i++) begin
				stp = longint'(atan_q30(i)) >>> (30 - ANGLE_FB);
				dx = y >>> i;
				dy = x >>> i;
				if (y > 0) begin
					x += dx; y -= dy; acc += stp;
				end else begin
					x -= dx; y += dy; acc -= stp;
				end
			end
			return base + acc;
		endfunction

		// Arccos of num/den; returns 0 when den is not positive or the ratio falls outside -1..1
		function bit arc_cosine(longint num, longint den, output longint ang);
			longint unsigned m, d;
			bit neg;
			longint n;
			ang = 0;
			neg = num < 0;
			m = neg ? -num : num;
			if (den <= 0 || m > unsigned'(den)) return 0;
			d = den;
			while (d >= (64'd1 << 30)) begin
				d >>= 1; m >>= 1;
			end
			while (d < (64'd1 << 29)) begin
				d <<= 1; m <<= 1;
			end
			n = neg ? -longint'(m) : longint'(m);
			ang = vector_angle(n, longint'(int_sqrt(d * d - m * m)));
			return 1;
		endfunction

		function longint degrees(longint a);
			longint unsigned mag;
			longint dg;
			mag = a < 0 ? -a : a;
			dg = (mag * DEG_PER_RAD_Q24) >> (ANGLE_FB + 24);
			return a < 0 ? -dg : dg;
		endfunction

		function bit [CMD_W-1:0] clamp(longint v);
			if (v < 0) return 0;
			if (v > longint'(CMD_MAX)) return CMD_MAX;
			return v[CMD_W-1:0];
		endfunction

		// Work out the servo commands for one accepted foot target
		function void note_target(logic signed [X_W-1:0] fx, logic [Z_W-1:0] fz, logic leg);
			longint x, z, lean, a1, a2, a3, l1, l2, r, l1s, l2s, rs, hip, knee, ankle;
			longint unsigned r2;
			bit ok;
			servo_cmd_t c;
			x = fx;
			z = fz;
			r2 = x * x + z * z;
			lean = vector_angle(z * 65536, x * 65536);
			r = int_sqrt(r2 << 8);
			l1 = upper_len << 4;
			l2 = lower_len << 4;
			l1s = l1 * l1;
			l2s = l2 * l2;
			rs = r2 << 8;
			ok = arc_cosine(l1s + rs - l2s, 2 * l1 * r, a1);
			ok = arc_cosine(l1s + l2s - rs, 2 * l1 * l2, a2) && ok;
			ok = arc_cosine(l2s + rs - l1s, 2 * l2 * r, a3) && ok;
			c.leg = leg;
			c.unreach = !ok;
			c.hip = 0;
			c.knee = 0;
			c.ankle = 0;
			if (ok) begin
				hip = degrees(a1 + lean);
				knee = degrees(2 * half_pi() - a2);
				ankle = degrees(half_pi() + lean - a3);
				if (!leg) begin
					c.hip = clamp(off_l_hip - hip);
					c.knee = clamp(off_l_knee - knee);
					c.ankle = clamp(2 * off_l_ankle - ankle);
				end else begin
					c.hip = clamp(off_r_hip + hip);
					c.knee = clamp(off_r_knee + knee);
					c.ankle = clamp(ankle);
				end
			end
			owed_q.push_back(c);
		endfunction

		function void check_word(logic [23:0] data, logic [1:0] user);
			servo_cmd_t e;
			if (owed_q.size() == 0) begin
				$error("output word with nothing owed: data %h user %b", data, user);
				errors++;
				return;
			end
			e = owed_q.pop_front();
			checked++;
			if (e.unreach) unreach_seen++;
			if (user[0] !== e.leg) begin
				$error("leg_out: expected %0d, got %0d", e.leg, user[0]);
				errors++;
			end
			if (user[1] !== e.unreach) begin
				$error("unreachable: expected %0d, got %0d", e.unreach, user[1]);
				errors++;
			end
			if (data[7:0] !== e.hip) begin
				$error("hip_command: expected %0d, got %0d", e.hip, data[7:0]);
				errors++;
			end
			if (data[15:8] !== e.knee) begin
				$error("knee_command: expected %0d, got %0d", e.knee, data[15:8]);
				errors++;
			end
			if (data[23:16] !== e.ankle) begin
				$error("ankle_command: expected %0d, got %0d", e.ankle, data[23:16]);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [31:0]      s_tdata;
	logic [0:0]       s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [23:0]      m_tdata;
	logic [1:0]       m_tuser;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	leg_scoreboard sb = new();
	bit  no_idle;       // hold both sides busy during the quiet stretch
	int  sent;
	int  stall_cycles;

	two_link_leg_inverse_kinematics DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Sample every handshake at the edge and feed the scoreboard
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_target(s_tdata[13:0], s_tdata[26:14], s_tuser[0]);
			if (m_tvalid && m_tready)
				sb.check_word(m_tdata, m_tuser);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	// Send one foot target; random gaps before it unless in the quiet stretch
	task automatic send_target(logic signed [X_W-1:0] fx, logic [Z_W-1:0] fz, logic leg);
		if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, fz, fx};
		s_tuser <= leg;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		sent++;
	endtask

	// Drop valid and wait for the pipeline to empty
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.owed_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(int up, int lo, int lh, int lk, int la, int rh, int rk);
		drain();
		write_reg(REG_UPPER_LEN, CFG_W'(up));
		write_reg(REG_LOWER_LEN, CFG_W'(lo));
		write_reg(REG_LEFT_HIP, CFG_W'(lh));
		write_reg(REG_LEFT_KNEE, CFG_W'(lk));
		write_reg(REG_LEFT_ANKLE, CFG_W'(la));
		write_reg(REG_RIGHT_HIP, CFG_W'(rh));
		write_reg(REG_RIGHT_KNEE, CFG_W'(rk));
	endtask

	// Mostly targets in a box bounded by the leg's reach, the rest anywhere in the field range
	task automatic random_targets(int count);
		int lim, xv, zv;
		for (int i = 0; i < count; i++) begin
			no_idle = (sent >= 900 && sent < 1150);
			lim = int'(sb.upper_len + sb.lower_len);
			if (lim > 8191) lim = 8191;
			if ($urandom_range(99) < 70) begin
				xv = int'($urandom_range(0, 2 * lim)) - lim;
				zv = $urandom_range(1, lim);
			end else begin
				xv = int'($urandom_range(0, 16383)) - 8192;
				zv = $urandom_range(0, 8191);
			end
			send_target(X_W'(xv), Z_W'(zv), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		no_idle = 0;
		sent = 0;
		stall_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed targets at reset lengths: extremes, straight leg, zero z, zero reach
		for (int leg = 0; leg < 2; leg++) begin
			send_target(-14'sd8192, 13'd8191, 1'(leg));
			send_target(14'sd8191, 13'd1, 1'(leg));
			send_target(14'sd0, 13'd2560, 1'(leg));
			send_target(14'sd0, 13'd1, 1'(leg));
			send_target(14'sd1000, 13'd0, 1'(leg));
			send_target(-14'sd1000, 13'd0, 1'(leg));
			send_target(14'sd0, 13'd0, 1'(leg));
			send_target(14'sd600, 13'd1800, 1'(leg));
			send_target(-14'sd900, 13'd1500, 1'(leg));
			send_target(14'sd1, 13'd1, 1'(leg));
		end
		random_targets(380);

		// Longest links, offsets at both ends; a write to the unused index is dropped
		write_all(8191, 8191, 0, 180, 180, 0, 180);
		write_reg(REG_UNUSED, 13'h1FFF);
		send_target(14'sd0, 13'd8191, 1'b0);
		send_target(-14'sd8192, 13'd8191, 1'b1);
		random_targets(300);

		write_all(8191, 8191, 180, 0, 0, 180, 0);
		random_targets(250);

		// Shortest links: nearly everything is out of reach
		write_all(1, 1, 90, 90, 90, 90, 90);
		send_target(14'sd0, 13'd2, 1'b0);
		send_target(14'sd1, 13'd1, 1'b1);
		random_targets(100);

		for (int p = 0; p < 3; p++) begin
			write_all($urandom_range(200, 3000), $urandom_range(200, 3000),
				$urandom_range(180), $urandom_range(180), $urandom_range(180),
				$urandom_range(180), $urandom_range(180));
			random_targets(300);
		end

		drain();
		$display("Sent %0d foot targets over 7 register settings; %0d results checked, %0d unreachable.",
			sent, sb.checked, sb.unreach_seen);
		if (sb.errors == 0 && sb.owed_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches, %0d results never arrived", sb.errors, sb.owed_q.size());
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

@@ files.f @@
+incdir+design
design/tlik_pkg.sv
design/tlik_isqrt.sv
design/tlik_cordic.sv
design/tlik_acos.sv
design/two_link_leg_inverse_kinematics.sv
tb/testbench.sv
